// ===== sv/bbg_pkg.sv =====
`default_nettype none
package bbg_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_CAM_X = 3'd0;
    localparam logic [2:0] CFG_CAM_Y = 3'd1;
    localparam logic [2:0] CFG_CAM_Z = 3'd2;
    localparam logic [2:0] CFG_UP_X  = 3'd3;
    localparam logic [2:0] CFG_UP_Y  = 3'd4;
    localparam logic [2:0] CFG_UP_Z  = 3'd5;

    // 1.0 in q2.14
    localparam logic signed [15:0] QONE = 16'sd16384;

    // width of a vector component entering the normalizer
    localparam int VEC_W = 34;

    typedef logic [2:0][VEC_W-1:0] nvec_t;
    typedef logic [2:0][15:0] vec14_t;

    typedef struct packed {
        logic              opcode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] upvec_x;
        logic signed [15:0] upvec_y;
        logic signed [15:0] upvec_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
        logic               degenerate;
    } out_item_t;

    // per-item control and partial results that ride along the pipeline
    typedef struct packed {
        logic   valid;
        logic   opcode;
        logic   deg;
        vec14_t d;
        vec14_t rt;
        vec14_t fw;
    } side_t;

endpackage
`default_nettype wire

// ===== sv/bbg_norm.sv =====
`default_nettype none
module bbg_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  bbg_pkg::nvec_t vec,
    input  bbg_pkg::side_t side_in,
    output bbg_pkg::vec14_t q,
    output logic           zero,
    output bbg_pkg::side_t side_out
);

    localparam int VW     = bbg_pkg::VEC_W;
    localparam int MAG_W  = 20;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int S_W    = SQ_W + 2;
    localparam int ROOT_W = S_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int QUO_W  = 15;
    localparam int FRAC   = 14;
    localparam int NUM_W  = MAG_W + FRAC + 1;
    localparam int POS_W  = 6;
    localparam logic [POS_W-1:0] TARGET = POS_W'(MAG_W - 1);

    typedef struct packed {
        bbg_pkg::side_t side;
        logic [2:0]     sgn;
        logic           zero;
    } ctl_t;

    // stage a: magnitudes and signs
    logic [2:0][VW-1:0] a_mag_next;
    logic [2:0][VW-1:0] a_mag_reg;
    logic [2:0]         a_sgn_reg;
    bbg_pkg::side_t     a_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag_next[i] = vec[i][VW-1] ? (~vec[i]) + VW'(1) : vec[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_side_reg <= '0;
        end
        else if (en)
        begin
            a_side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg <= a_mag_next;
            for (int i = 0; i < 3; i++)
            begin
                a_sgn_reg[i] <= vec[i][VW-1];
            end
        end
    end

    // stage b: largest magnitude and its leading one
    logic [VW-1:0]      b_max;
    logic [POS_W-1:0]   b_pos_next;
    logic [2:0][VW-1:0] b_mag_reg;
    logic [POS_W-1:0]   b_pos_reg;
    ctl_t               b_ctl_reg;

    always_comb
    begin
        b_max = a_mag_reg[0];
        if (a_mag_reg[1] > b_max)
        begin
            b_max = a_mag_reg[1];
        end
        if (a_mag_reg[2] > b_max)
        begin
            b_max = a_mag_reg[2];
        end
        b_pos_next = '0;
        for (int b = 0; b < VW; b++)
        begin
            if (b_max[b])
            begin
                b_pos_next = POS_W'(b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctl_reg <= '0;
        end
        else if (en)
        begin
            b_ctl_reg.side <= a_side_reg;
            b_ctl_reg.sgn  <= a_sgn_reg;
            b_ctl_reg.zero <= (b_max == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_mag_reg <= a_mag_reg;
            b_pos_reg <= b_pos_next;
        end
    end

    // stage c: bring the largest magnitude into [2^19, 2^20)
    logic [2:0][MAG_W-1:0] c_mag_next;
    logic [2:0][MAG_W-1:0] c_mag_reg;
    ctl_t                  c_ctl_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b_pos_reg >= TARGET)
            begin
                c_mag_next[i] = MAG_W'(b_mag_reg[i] >> (b_pos_reg - TARGET));
            end
            else
            begin
                c_mag_next[i] = MAG_W'(b_mag_reg[i] << (TARGET - b_pos_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctl_reg <= '0;
        end
        else if (en)
        begin
            c_ctl_reg <= b_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_mag_reg <= c_mag_next;
        end
    end

    // stage d: squares
    logic [2:0][SQ_W-1:0]  d_sq_reg;
    logic [2:0][MAG_W-1:0] d_mag_reg;
    ctl_t                  d_ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_ctl_reg <= '0;
        end
        else if (en)
        begin
            d_ctl_reg <= c_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_mag_reg <= c_mag_reg;
            for (int i = 0; i < 3; i++)
            begin
                d_sq_reg[i] <= c_mag_reg[i] * c_mag_reg[i];
            end
        end
    end

    // square root pipeline, one root bit per stage; entry 0 holds the sum
    logic [S_W-1:0]        sq_s_reg    [0:ROOT_W];
    logic [ROOT_W-1:0]     sq_root_reg [0:ROOT_W];
    logic [REM_W-1:0]      sq_rem_reg  [0:ROOT_W];
    logic [2:0][MAG_W-1:0] sq_mag_reg  [0:ROOT_W];
    ctl_t                  sq_ctl_reg  [0:ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            sq_ctl_reg[0] <= d_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_s_reg[0]    <= S_W'(d_sq_reg[0]) + S_W'(d_sq_reg[1]) + S_W'(d_sq_reg[2]);
            sq_root_reg[0] <= '0;
            sq_rem_reg[0]  <= '0;
            sq_mag_reg[0]  <= d_mag_reg;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        localparam int BIT = 2 * (ROOT_W - 1 - k);
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             take;

        assign rem_sh = {sq_rem_reg[k], sq_s_reg[k][BIT+1:BIT]};
        assign trial  = {1'b0, sq_root_reg[k], 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_ctl_reg[k+1] <= '0;
            end
            else if (en)
            begin
                sq_ctl_reg[k+1] <= sq_ctl_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_s_reg[k+1]    <= sq_s_reg[k];
                sq_mag_reg[k+1]  <= sq_mag_reg[k];
                sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_W-2:0], take};
                if (take)
                begin
                    sq_rem_reg[k+1] <= REM_W'(rem_sh - trial);
                end
                else
                begin
                    sq_rem_reg[k+1] <= REM_W'(rem_sh);
                end
            end
        end
    end

    // division pipeline; entry 0 holds the rounded numerators
    logic [2:0][NUM_W-1:0] dv_r_reg [0:QUO_W];
    logic [2:0][QUO_W-1:0] dv_q_reg [0:QUO_W];
    logic [ROOT_W-1:0]     dv_d_reg [0:QUO_W];
    ctl_t                  dv_ctl_reg [0:QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_ctl_reg[0] <= '0;
        end
        else if (en)
        begin
            dv_ctl_reg[0] <= sq_ctl_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_d_reg[0] <= sq_root_reg[ROOT_W];
            dv_q_reg[0] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                dv_r_reg[0][i] <= {1'b0, sq_mag_reg[ROOT_W][i], FRAC'(0)}
                                  + NUM_W'(sq_root_reg[ROOT_W] >> 1);
            end
        end
    end

    for (genvar t = 0; t < QUO_W; t++)
    begin : g_div
        localparam int QB = QUO_W - 1 - t;
        logic [NUM_W-1:0]      trial;
        logic [2:0][NUM_W-1:0] r_next;
        logic [2:0][QUO_W-1:0] q_next;

        assign trial = NUM_W'(dv_d_reg[t]) << QB;

        always_comb
        begin
            r_next = dv_r_reg[t];
            q_next = dv_q_reg[t];
            for (int i = 0; i < 3; i++)
            begin
                if (dv_r_reg[t][i] >= trial)
                begin
                    r_next[i]     = dv_r_reg[t][i] - trial;
                    q_next[i][QB] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_ctl_reg[t+1] <= '0;
            end
            else if (en)
            begin
                dv_ctl_reg[t+1] <= dv_ctl_reg[t];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_d_reg[t+1] <= dv_d_reg[t];
                dv_r_reg[t+1] <= r_next;
                dv_q_reg[t+1] <= q_next;
            end
        end
    end

    // output: restore signs, zero vector gives zero
    bbg_pkg::vec14_t q_next;
    bbg_pkg::vec14_t q_reg;
    logic            zero_reg;
    bbg_pkg::side_t  side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_ctl_reg[QUO_W].zero)
            begin
                q_next[i] = '0;
            end
            else if (dv_ctl_reg[QUO_W].sgn[i])
            begin
                q_next[i] = 16'(-{1'b0, dv_q_reg[QUO_W][i]});
            end
            else
            begin
                q_next[i] = {1'b0, dv_q_reg[QUO_W][i]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
            zero_reg <= 1'b0;
        end
        else if (en)
        begin
            side_reg <= dv_ctl_reg[QUO_W].side;
            zero_reg <= dv_ctl_reg[QUO_W].zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q        = q_reg;
    assign zero     = zero_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

// ===== sv/billboard_basis_generator_core.sv =====
`default_nettype none
// channel  | signals                               | direction
// ---------+---------------------------------------+----------------------
// input    | in_valid, in_stall, in_item           | object position, mode
// output   | out_valid, out_stall, out_item        | basis rows, flag
// config   | cfg_valid, cfg_ready, cfg_index, data | camera, view up
//
// one request per cycle unless the output stalls on a held result: three
// normalizers of 43 stages each (21-stage square root, 15-stage divider)
// plus five glue stages. reset clears all valid bits; the view up normalizer
// runs free, also during a stall, and settles after reset or a view up write.
// a stall on a held result freezes the rest of the pipeline, including the input side.
module billboard_basis_generator_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bbg_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output bbg_pkg::out_item_t  out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int VW   = bbg_pkg::VEC_W;
    localparam int CR_W = 31;

    typedef logic [2:0][CR_W-1:0] cvec_t;

    function automatic cvec_t cross3(bbg_pkg::vec14_t a, bbg_pkg::vec14_t b);
        logic signed [31:0] p [0:5];
        cvec_t c;
        p[0] = $signed(a[1]) * $signed(b[2]);
        p[1] = $signed(a[2]) * $signed(b[1]);
        p[2] = $signed(a[2]) * $signed(b[0]);
        p[3] = $signed(a[0]) * $signed(b[2]);
        p[4] = $signed(a[0]) * $signed(b[1]);
        p[5] = $signed(a[1]) * $signed(b[0]);
        c[0] = CR_W'(p[0] - p[1]);
        c[1] = CR_W'(p[2] - p[3]);
        c[2] = CR_W'(p[4] - p[5]);
        return c;
    endfunction

    // negated q3.28 value rounded half away from zero into q2.14, saturated
    function automatic logic [15:0] neg_round(logic [CR_W-1:0] v);
        logic [CR_W-1:0] mag;
        logic [CR_W-1:0] rnd;
        logic [15:0]     u;
        mag = v[CR_W-1] ? (~v) + CR_W'(1) : v;
        rnd = (mag + CR_W'(8192)) >> 14;
        if (rnd > CR_W'(bbg_pkg::QONE))
        begin
            u = bbg_pkg::QONE;
        end
        else
        begin
            u = rnd[15:0];
        end
        return v[CR_W-1] ? u : 16'(-u);
    endfunction

    function automatic bbg_pkg::nvec_t widen(cvec_t v);
        bbg_pkg::nvec_t w;
        for (int i = 0; i < 3; i++)
        begin
            w[i] = {{(VW-CR_W){v[i][CR_W-1]}}, v[i]};
        end
        return w;
    endfunction

    logic en;

    // configuration registers
    logic [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [15:0] up_x_reg, up_y_reg, up_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            up_x_reg  <= '0;
            up_y_reg  <= bbg_pkg::QONE;
            up_z_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bbg_pkg::CFG_CAM_X: cam_x_reg <= cfg_data;
                bbg_pkg::CFG_CAM_Y: cam_y_reg <= cfg_data;
                bbg_pkg::CFG_CAM_Z: cam_z_reg <= cfg_data;
                bbg_pkg::CFG_UP_X:  up_x_reg  <= cfg_data[15:0];
                bbg_pkg::CFG_UP_Y:  up_y_reg  <= cfg_data[15:0];
                bbg_pkg::CFG_UP_Z:  up_z_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a finished result is held by an output stall
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // stage t0: difference vector
    bbg_pkg::nvec_t t0_diff_next;
    bbg_pkg::nvec_t t0_diff_reg;
    bbg_pkg::side_t t0_side_next;
    bbg_pkg::side_t t0_side_reg;
    logic [2:0][32:0] pos_e, cam_e;

    always_comb
    begin
        pos_e[0] = {in_item.pos_x[31], in_item.pos_x};
        pos_e[1] = {in_item.pos_y[31], in_item.pos_y};
        pos_e[2] = {in_item.pos_z[31], in_item.pos_z};
        cam_e[0] = {cam_x_reg[31], cam_x_reg};
        cam_e[1] = {cam_y_reg[31], cam_y_reg};
        cam_e[2] = {cam_z_reg[31], cam_z_reg};
        for (int i = 0; i < 3; i++)
        begin
            if (in_item.opcode)
            begin
                t0_diff_next[i] = VW'($signed(pos_e[i] - cam_e[i]));
            end
            else
            begin
                t0_diff_next[i] = VW'($signed(cam_e[i] - pos_e[i]));
            end
        end
        t0_side_next        = '0;
        t0_side_next.valid  = in_valid;
        t0_side_next.opcode = in_item.opcode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_side_reg <= '0;
        end
        else if (en)
        begin
            t0_side_reg <= t0_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_diff_reg <= t0_diff_next;
        end
    end

    // direction normalizer
    bbg_pkg::vec14_t n1_q;
    logic            n1_zero;
    bbg_pkg::side_t  n1_side;

    bbg_norm u_norm_dir (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vec      (t0_diff_reg),
        .side_in  (t0_side_reg),
        .q        (n1_q),
        .zero     (n1_zero),
        .side_out (n1_side)
    );

    // view up normalizer, free running on the registers
    bbg_pkg::nvec_t  vu_vec;
    bbg_pkg::vec14_t vu_q;
    logic            vu_zero;

    assign vu_vec[0] = {{(VW-16){up_x_reg[15]}}, up_x_reg};
    assign vu_vec[1] = {{(VW-16){up_y_reg[15]}}, up_y_reg};
    assign vu_vec[2] = {{(VW-16){up_z_reg[15]}}, up_z_reg};

    bbg_norm u_norm_vup (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (1'b1),
        .vec      (vu_vec),
        .side_in  ('0),
        .q        (vu_q),
        .zero     (vu_zero),
        .side_out ()
    );

    // stage g1: vector to normalize into right
    cvec_t          g1_vec_next;
    cvec_t          g1_vec_reg;
    bbg_pkg::side_t g1_side_next;
    bbg_pkg::side_t g1_side_reg;

    always_comb
    begin
        if (n1_side.opcode)
        begin
            g1_vec_next = cross3(n1_q, vu_q);
        end
        else
        begin
            g1_vec_next[0] = CR_W'(-$signed(n1_q[2]));
            g1_vec_next[1] = '0;
            g1_vec_next[2] = CR_W'($signed(n1_q[0]));
        end
        g1_side_next     = n1_side;
        g1_side_next.d   = n1_q;
        g1_side_next.deg = n1_zero || (n1_side.opcode && vu_zero);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_side_reg <= '0;
        end
        else if (en)
        begin
            g1_side_reg <= g1_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_vec_reg <= g1_vec_next;
        end
    end

    // right normalizer
    bbg_pkg::vec14_t n3_q;
    logic            n3_zero;
    bbg_pkg::side_t  n3_side;

    bbg_norm u_norm_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vec      (widen(g1_vec_reg)),
        .side_in  (g1_side_reg),
        .q        (n3_q),
        .zero     (n3_zero),
        .side_out (n3_side)
    );

    // stage g2a: d x right
    cvec_t          g2a_c_reg;
    bbg_pkg::side_t g2a_side_next;
    bbg_pkg::side_t g2a_side_reg;

    always_comb
    begin
        g2a_side_next     = n3_side;
        g2a_side_next.rt  = n3_q;
        g2a_side_next.deg = n3_side.deg || n3_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g2a_side_reg <= '0;
        end
        else if (en)
        begin
            g2a_side_reg <= g2a_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g2a_c_reg <= cross3(n3_side.d, n3_q);
        end
    end

    // stage g2b: cylindrical direction row is right x d, rounded
    cvec_t          g2b_c_reg;
    bbg_pkg::side_t g2b_side_next;
    bbg_pkg::side_t g2b_side_reg;

    always_comb
    begin
        g2b_side_next = g2a_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            g2b_side_next.fw[i] = neg_round(g2a_c_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g2b_side_reg <= '0;
        end
        else if (en)
        begin
            g2b_side_reg <= g2b_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g2b_c_reg <= g2a_c_reg;
        end
    end

    // spherical up normalizer
    bbg_pkg::vec14_t n4_q;
    logic            n4_zero;
    bbg_pkg::side_t  n4_side;

    bbg_norm u_norm_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vec      (widen(g2b_c_reg)),
        .side_in  (g2b_side_reg),
        .q        (n4_q),
        .zero     (n4_zero),
        .side_out (n4_side)
    );

    // output register
    bbg_pkg::out_item_t out_item_next;
    bbg_pkg::out_item_t out_item_reg;
    logic               out_valid_reg;

    always_comb
    begin
        out_item_next.right_x = n4_side.rt[0];
        out_item_next.right_y = n4_side.rt[1];
        out_item_next.right_z = n4_side.rt[2];
        if (n4_side.opcode)
        begin
            out_item_next.upvec_x    = n4_q[0];
            out_item_next.upvec_y    = n4_q[1];
            out_item_next.upvec_z    = n4_q[2];
            out_item_next.fwd_x      = n4_side.d[0];
            out_item_next.fwd_y      = n4_side.d[1];
            out_item_next.fwd_z      = n4_side.d[2];
            out_item_next.degenerate = n4_side.deg || n4_zero;
        end
        else
        begin
            out_item_next.upvec_x    = '0;
            out_item_next.upvec_y    = bbg_pkg::QONE;
            out_item_next.upvec_z    = '0;
            out_item_next.fwd_x      = n4_side.fw[0];
            out_item_next.fwd_y      = n4_side.fw[1];
            out_item_next.fwd_z      = n4_side.fw[2];
            out_item_next.degenerate = n4_side.deg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= n4_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    // a non-degenerate result always has a nonzero right vector
    a_right_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.degenerate |->
            (out_item.right_x != 0 || out_item.right_y != 0 || out_item.right_z != 0))
        else $error("right vector zero without degenerate flag");

    // the checked right x, up y and forward z components stay within one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            ($signed(out_item.right_x) <= 16384 && $signed(out_item.right_x) >= -16384 &&
             $signed(out_item.upvec_y) <= 16384 && $signed(out_item.upvec_y) >= -16384 &&
             $signed(out_item.fwd_z) <= 16384 && $signed(out_item.fwd_z) >= -16384))
        else $error("basis component out of range");

    // a held result freezes the interior stages
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(g2b_side_reg) && $stable(t0_side_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

// ===== dv/billboard_basis_generator_core_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module billboard_basis_generator_core_test;

    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } v3_t;

    typedef struct {
        logic      opcode;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        bit        typed;
        bbg_pkg::out_item_t want;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    bbg_pkg::in_item_t   in_item;
    logic       out_valid;
    logic       out_stall;
    bbg_pkg::out_item_t  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    // predictor copy of the registers
    logic signed [31:0] cam_q [3];
    logic signed [15:0] vup_q [3];

    bbg_pkg::out_item_t basis_q [$];
    int        fails;
    bit        idle_on;
    bit        hold_trigger;
    int        hold_left;
    row_t      rows [$];

    billboard_basis_generator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("Verification failed");
        $finish;
    end

    // floor square root, bit by bit
    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > s)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (s >= res + bt)
            begin
                s = s - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    // scale to q2.14 unit length, flags a zero vector
    function automatic v3_t unit_vec(v3_t v, inout bit deg);
        longint          a [3];
        longint unsigned mg [3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned r;
        longint unsigned u;
        v3_t             q;
        a[0] = v.x;
        a[1] = v.y;
        a[2] = v.z;
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            mg[i] = (a[i] < 0) ? -a[i] : a[i];
            if (mg[i] > m)
                m = mg[i];
        end
        if (m == 0)
        begin
            deg = 1'b1;
            return '0;
        end
        while (m >= (64'd1 << 20))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                mg[i] = mg[i] >> 1;
        end
        while (m < (64'd1 << 19))
        begin
            m = m << 1;
            for (int i = 0; i < 3; i++)
                mg[i] = mg[i] << 1;
        end
        s = 0;
        for (int i = 0; i < 3; i++)
            s = s + mg[i] * mg[i];
        r = root_floor(s);
        for (int i = 0; i < 3; i++)
        begin
            u = (mg[i] * 16384 + (r >> 1)) / r;
            a[i] = (a[i] < 0) ? -longint'(u) : longint'(u);
        end
        q.x = a[0];
        q.y = a[1];
        q.z = a[2];
        return q;
    endfunction

    function automatic v3_t cross_prod(v3_t a, v3_t b);
        v3_t c;
        c.x = a.y * b.z - a.z * b.y;
        c.y = a.z * b.x - a.x * b.z;
        c.z = a.x * b.y - a.y * b.x;
        return c;
    endfunction

    // q4.28 to q2.14, half away from zero, saturated
    function automatic logic signed [15:0] round_q14(longint v);
        longint unsigned mg;
        mg = (v < 0) ? -v : v;
        mg = (mg + 8192) >> 14;
        if (mg > 16384)
            mg = 16384;
        return 16'((v < 0) ? -longint'(mg) : longint'(mg));
    endfunction

    function automatic bbg_pkg::out_item_t billboard_basis(bbg_pkg::in_item_t it);
        v3_t       diff;
        v3_t       d;
        v3_t       rt;
        v3_t       up;
        v3_t       fw;
        v3_t       tmp;
        v3_t       vu;
        bit        deg;
        bbg_pkg::out_item_t o;
        deg = 1'b0;
        if (it.opcode == 1'b0)
        begin
            diff.x = longint'(cam_q[0]) - longint'(it.pos_x);
            diff.y = longint'(cam_q[1]) - longint'(it.pos_y);
            diff.z = longint'(cam_q[2]) - longint'(it.pos_z);
            d = unit_vec(diff, deg);
            tmp.x = -d.z;
            tmp.y = 0;
            tmp.z = d.x;
            rt = unit_vec(tmp, deg);
            up.x = 0;
            up.y = bbg_pkg::QONE;
            up.z = 0;
            tmp = cross_prod(rt, d);
            fw.x = round_q14(tmp.x);
            fw.y = round_q14(tmp.y);
            fw.z = round_q14(tmp.z);
        end
        else
        begin
            diff.x = longint'(it.pos_x) - longint'(cam_q[0]);
            diff.y = longint'(it.pos_y) - longint'(cam_q[1]);
            diff.z = longint'(it.pos_z) - longint'(cam_q[2]);
            d = unit_vec(diff, deg);
            vu.x = vup_q[0];
            vu.y = vup_q[1];
            vu.z = vup_q[2];
            vu = unit_vec(vu, deg);
            rt = unit_vec(cross_prod(d, vu), deg);
            up = unit_vec(cross_prod(d, rt), deg);
            fw = d;
        end
        o.right_x = rt.x[15:0];
        o.right_y = rt.y[15:0];
        o.right_z = rt.z[15:0];
        o.upvec_x = up.x[15:0];
        o.upvec_y = up.y[15:0];
        o.upvec_z = up.z[15:0];
        o.fwd_x = fw.x[15:0];
        o.fwd_y = fw.y[15:0];
        o.fwd_z = fw.z[15:0];
        o.degenerate = deg;
        return o;
    endfunction

    function automatic void split_fields(bbg_pkg::out_item_t o, output logic [15:0] f [10]);
        f[0] = o.right_x;
        f[1] = o.right_y;
        f[2] = o.right_z;
        f[3] = o.upvec_x;
        f[4] = o.upvec_y;
        f[5] = o.upvec_z;
        f[6] = o.fwd_x;
        f[7] = o.fwd_y;
        f[8] = o.fwd_z;
        f[9] = {15'd0, o.degenerate};
    endfunction

    // result checker and receiver stall
    always @(posedge clk)
    begin
        logic [15:0] fw [10];
        logic [15:0] fa [10];
        bbg_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (basis_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_item);
                fails++;
            end
            else
            begin
                want = basis_q.pop_front();
                split_fields(want, fw);
                split_fields(out_item, fa);
                for (int i = 0; i < 10; i++)
                    if (fw[i] !== fa[i])
                    begin
                        $display("%0t: field %0d expected %h actual %h",
                                 $time, i, fw[i], fa[i]);
                        fails++;
                    end
            end
        end
        if (hold_trigger)
        begin
            hold_trigger = 1'b0;
            hold_left = 500;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_on && ($urandom_range(99) < 9);
    end

    task automatic send_req(bbg_pkg::in_item_t it, bit typed, bbg_pkg::out_item_t want);
        int gap;
        if (idle_on && $urandom_range(99) < 9)
        begin
            gap = $urandom_range(4, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (in_stall);
        basis_q.push_back(typed ? want : billboard_basis(it));
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        while (basis_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // write all six registers, then let the view up normalizer settle
    task automatic write_regs(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [15:0] ux, logic [15:0] uy, logic [15:0] uz);
        logic [31:0] vals [6];
        vals = '{cx, cy, cz, {16'd0, ux}, {16'd0, uy}, {16'd0, uz}};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cam_q[bbg_pkg::CFG_CAM_X] = cx;
        cam_q[bbg_pkg::CFG_CAM_Y] = cy;
        cam_q[bbg_pkg::CFG_CAM_Z] = cz;
        vup_q[bbg_pkg::CFG_UP_X - 3] = ux;
        vup_q[bbg_pkg::CFG_UP_Y - 3] = uy;
        vup_q[bbg_pkg::CFG_UP_Z - 3] = uz;
        repeat (100) @(posedge clk);
    endtask

    // mostly near the camera, some full range, some corners
    function automatic logic [31:0] pick_coord(logic [31:0] c);
        int k;
        k = $urandom_range(99);
        if (k < 55)
            return c + 32'($signed($urandom_range(2097152)) - 1048576);
        else if (k < 65)
            return c;
        else if (k < 90)
            return $urandom;
        else if (k < 95)
            return 32'h7fffffff;
        else
            return 32'h80000000;
    endfunction

    function automatic bbg_pkg::out_item_t basis_of(logic [15:0] r [3], logic [15:0] u [3],
                                                    logic [15:0] f [3], logic dg);
        bbg_pkg::out_item_t o;
        o = {r[0], r[1], r[2], u[0], u[1], u[2], f[0], f[1], f[2], dg};
        return o;
    endfunction

    task automatic add_row(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           bit typed, bbg_pkg::out_item_t want);
        row_t r;
        r.opcode = op;
        r.px = x;
        r.py = y;
        r.pz = z;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endtask

    initial
    begin
        bbg_pkg::in_item_t    it;
        bbg_pkg::out_item_t   none;
        logic [31:0] cv [3];
        logic [15:0] uv [3];
        fails = 0;
        idle_on = 1'b1;
        hold_trigger = 1'b0;
        hold_left = 0;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cam_q = '{0, 0, 0};
        vup_q = '{16'sd0, bbg_pkg::QONE, 16'sd0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (100) @(posedge clk);

        // directed rows at reset settings
        add_row(1'b0, 0, 0, 0, 1'b1,
                basis_of('{0, 0, 0}, '{0, 16384, 0}, '{0, 0, 0}, 1'b1));
        add_row(1'b0, -32'sd65536, 0, 0, 1'b1,
                basis_of('{0, 0, 16384}, '{0, 16384, 0}, '{0, 16384, 0}, 1'b0));
        add_row(1'b0, 0, -32'sd65536, 0, 1'b1,
                basis_of('{0, 0, 0}, '{0, 16384, 0}, '{0, 0, 0}, 1'b1));
        add_row(1'b0, 0, 32'sd123456, 0, 1'b1,
                basis_of('{0, 0, 0}, '{0, 16384, 0}, '{0, 0, 0}, 1'b1));
        add_row(1'b1, 0, 0, 0, 1'b1,
                basis_of('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, 1'b1));
        add_row(1'b1, 0, 0, 32'sd65536, 1'b1,
                basis_of('{-16'sd16384, 0, 0}, '{0, -16'sd16384, 0}, '{0, 0, 16384}, 1'b0));
        add_row(1'b1, 0, 32'sd65536, 0, 1'b1,
                basis_of('{0, 0, 0}, '{0, 0, 0}, '{0, 16384, 0}, 1'b1));
        add_row(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, none);
        add_row(1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, none);
        add_row(1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0, none);
        add_row(1'b1, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, none);
        add_row(1'b0, 1, 0, 32'hffffffff, 1'b0, none);
        add_row(1'b1, 32'hffffffff, 1, 1, 1'b0, none);
        add_row(1'b0, 32'h00012345, 32'hfff00000, 32'h7654321, 1'b0, none);
        add_row(1'b1, 32'h00012345, 32'hfff00000, 32'h7654321, 1'b0, none);
        foreach (rows[i])
        begin
            it.opcode = rows[i].opcode;
            it.pos_x = rows[i].px;
            it.pos_y = rows[i].py;
            it.pos_z = rows[i].pz;
            send_req(it, rows[i].typed, rows[i].want);
        end
        drain_wait();

        // random phases over several register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    cv = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
                    uv = '{16'h7fff, 16'h7fff, 16'h7fff};
                end
                1:
                begin
                    cv = '{32'h80000000, 32'h80000000, 32'h80000000};
                    uv = '{16'h8000, 16'h8000, 16'h8000};
                end
                2:
                begin
                    cv = '{32'h0, 32'h0, 32'h0};
                    uv = '{16'h0, 16'h0, 16'h0};
                end
                3:
                begin
                    cv = '{32'h00010000, 32'h00050000, 32'hfffd0000};
                    uv = '{16'h0000, 16'h4000, 16'h0000};
                end
                default:
                begin
                    cv = '{$urandom, $urandom, $urandom};
                    uv = '{16'($urandom), 16'($urandom), 16'($urandom)};
                end
            endcase
            write_regs(cv[0], cv[1], cv[2], uv[0], uv[1], uv[2]);
            idle_on = (ph != 4);
            if (ph == 5)
                hold_trigger = 1'b1;
            for (int n = 0; n < 210; n++)
            begin
                it.opcode = 1'($urandom);
                it.pos_x = pick_coord(cv[0]);
                it.pos_y = pick_coord(cv[1]);
                it.pos_z = pick_coord(cv[2]);
                send_req(it, 1'b0, none);
                // in phase 6 the sender once waits for the pipeline to empty
                if (ph == 6 && n == 100)
                begin
                    in_valid <= 1'b0;
                    while (basis_q.size() != 0)
                        @(posedge clk);
                end
            end
            drain_wait();
        end

        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
